// ----- hdl/lfu_cache_with_expiry_top_macros.svh -----
// Assertion macros used by the checker file.
`ifndef LFU_CACHE_WITH_EXPIRY_TOP_MACROS_SVH
`define LFU_CACHE_WITH_EXPIRY_TOP_MACROS_SVH

// The consequent must hold whenever the antecedent holds.
`define LFUCX_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfucx check failed");

// The consequent must hold in the cycle after the antecedent.
`define LFUCX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfucx check failed");

`endif

// ----- hdl/lfucx_pkg.sv -----
// ----------------------------------------------------------------------------
// lfucx_pkg
// Types and constants of the LFU cache with entry expiry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lfucx_pkg;
  localparam int COUNT_W = 16;
  localparam int STAMP_W = 32;
  localparam int TIME_W  = 32;
  localparam int TOTAL_W = 32;
  localparam int SECS_W  = 16;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    KIND_GET    = 3'd0,
    KIND_PUT    = 3'd1,
    KIND_ERASE  = 3'd2,
    KIND_SETEXP = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic found;
    logic victim_ok;
    logic free_ok;
  } scan_flags_t;
endpackage
`default_nettype wire

// ----- hdl/lfucx_ram.sv -----
// ----------------------------------------------------------------------------
// lfucx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lfucx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/lfucx_scan.sv -----
// ----------------------------------------------------------------------------
// lfucx_scan
// Shared compare unit: looks at one entry per cycle while cmp_en is high, and
// keeps the key match, eviction candidate, first free slot and live count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lfucx_scan #(
  parameter int ENTRIES   = 16,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          clear,
  input  wire logic                                          cmp_en,
  input  wire logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] cmp_idx,
  input  wire logic                                          cmp_valid,
  input  wire logic [KEY_BITS-1:0]                           cmp_key,
  input  wire logic [DATA_BITS-1:0]                          cmp_data,
  input  wire logic [lfucx_pkg::COUNT_W-1:0]                 cmp_count,
  input  wire logic [lfucx_pkg::STAMP_W-1:0]                 cmp_stamp,
  input  wire logic [lfucx_pkg::TIME_W-1:0]                  cmp_dl,
  input  wire logic [KEY_BITS-1:0]                           key,
  output lfucx_pkg::scan_flags_t                             flags,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]   match_idx,
  output logic [DATA_BITS-1:0]                               m_data,
  output logic [lfucx_pkg::COUNT_W-1:0]                      m_count,
  output logic [lfucx_pkg::STAMP_W-1:0]                      m_stamp,
  output logic [lfucx_pkg::TIME_W-1:0]                       m_dl,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]   vic_idx,
  output logic [KEY_BITS-1:0]                                vic_key,
  output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]   free_idx,
  output logic [$clog2(ENTRIES + 1)-1:0]                     live
);
  import lfucx_pkg::*;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  scan_flags_t          flags_r;
  logic [IDX_W-1:0]     match_idx_r, vic_idx_r, free_idx_r;
  logic [DATA_BITS-1:0] m_data_r;
  logic [COUNT_W-1:0]   m_count_r, vic_count_r;
  logic [STAMP_W-1:0]   m_stamp_r, vic_stamp_r;
  logic [TIME_W-1:0]    m_dl_r;
  logic [KEY_BITS-1:0]  vic_key_r;
  logic [CNT_W-1:0]     live_r;
  logic                 is_match, is_better;

  assign is_match  = cmp_valid && (cmp_key == key) && !flags_r.found;
  // Strict compare keeps the lowest index among equal count and stamp.
  assign is_better = cmp_valid && (!flags_r.victim_ok || (cmp_count < vic_count_r) ||
                     ((cmp_count == vic_count_r) && (cmp_stamp < vic_stamp_r)));

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      flags_r <= '0;
      live_r  <= '0;
    end else if (cmp_en) begin
      if (is_match) begin
        flags_r.found <= 1'b1;
      end
      if (is_better) begin
        flags_r.victim_ok <= 1'b1;
      end
      if (!cmp_valid) begin
        flags_r.free_ok <= 1'b1;
      end
      if (cmp_valid) begin
        live_r <= live_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      if (is_match) begin
        match_idx_r <= cmp_idx;
        m_data_r    <= cmp_data;
        m_count_r   <= cmp_count;
        m_stamp_r   <= cmp_stamp;
        m_dl_r      <= cmp_dl;
      end
      if (is_better) begin
        vic_idx_r   <= cmp_idx;
        vic_count_r <= cmp_count;
        vic_stamp_r <= cmp_stamp;
        vic_key_r   <= cmp_key;
      end
      if (!cmp_valid && !flags_r.free_ok) begin
        free_idx_r <= cmp_idx;
      end
    end
  end

  assign flags     = flags_r;
  assign match_idx = match_idx_r;
  assign m_data    = m_data_r;
  assign m_count   = m_count_r;
  assign m_stamp   = m_stamp_r;
  assign m_dl      = m_dl_r;
  assign vic_idx   = vic_idx_r;
  assign vic_key   = vic_key_r;
  assign free_idx  = free_idx_r;
  assign live      = live_r;
endmodule
`default_nettype wire

// ----- hdl/lfu_cache_with_expiry_top.sv -----
// An accepted item passes through the scan reads of every entry (ST_SCAN), the last
// compare (ST_LAST), the update (ST_EXEC) and the result cycle.
// No new item is taken while busy; busy is low in the result cycle.
// The result is shown for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the cache, clears time, stamps and
// counters, and sets capacity to 16.
// ----------------------------------------------------------------------------
// lfu_cache_with_expiry_top
// LFU key/value cache with entry expiry, scanned one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_with_expiry_top #(
  parameter int ENTRIES   = 16,
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [2:0]                     in_kind,
  input  wire logic [KEY_BITS-1:0]            in_key,
  input  wire logic [DATA_BITS-1:0]           in_value,
  input  wire logic [lfucx_pkg::SECS_W-1:0]   in_seconds,
  input  wire logic                           cfg_we,
  input  wire logic [lfucx_pkg::CAP_W-1:0]    cfg_wdata,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [DATA_BITS-1:0]                out_read_value,
  output logic [lfucx_pkg::TOTAL_W-1:0]       out_hit_count,
  output logic [lfucx_pkg::TOTAL_W-1:0]       out_miss_count,
  output logic                                out_evicted,
  output logic [KEY_BITS-1:0]                 out_evicted_key
);
  import lfucx_pkg::*;
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W = KEY_BITS + DATA_BITS + COUNT_W + STAMP_W + TIME_W;
  localparam int STAMP_LO = TIME_W;
  localparam int COUNT_LO = TIME_W + STAMP_W;
  localparam int DATA_LO  = COUNT_LO + COUNT_W;
  localparam int KEY_LO   = DATA_LO + DATA_BITS;

  state_t state_r, state_nxt;
  logic [2:0]           kind_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [DATA_BITS-1:0] value_r;
  logic [SECS_W-1:0]    secs_r;
  logic [CAP_W-1:0]     cap_r;
  logic [IDX_W-1:0]     addr_r, addr_nxt;
  logic                 cmp_en_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic [ENTRIES-1:0]   valid_r, valid_nxt, hasdl_r, hasdl_nxt;
  logic [TIME_W-1:0]    now_r, now_nxt;
  logic [STAMP_W-1:0]   seq_r, seq_nxt;
  logic [TOTAL_W-1:0]   hits_r, hits_nxt, misses_r, misses_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata, ram_rdata;

  scan_flags_t          flags;
  logic [IDX_W-1:0]     match_idx, vic_idx, free_idx, slot;
  logic [DATA_BITS-1:0] m_data;
  logic [COUNT_W-1:0]   m_count;
  logic [STAMP_W-1:0]   m_stamp;
  logic [TIME_W-1:0]    m_dl, m_dl_upd;
  logic [KEY_BITS-1:0]  vic_key;
  logic [CNT_W-1:0]     live;
  logic [CMP_W-1:0]     cap_eff;
  logic [TIME_W:0]      dl_sum;
  logic                 do_evict, expired, clear;

  logic                 hit_nxt, ev_nxt;
  logic [DATA_BITS-1:0] rd_nxt;
  logic [KEY_BITS-1:0]  evk_nxt;

  lfucx_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  lfucx_scan #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (clear),
    .cmp_en    (cmp_en_r),
    .cmp_idx   (cmp_idx_r),
    .cmp_valid (valid_r[cmp_idx_r]),
    .cmp_key   (ram_rdata[KEY_LO +: KEY_BITS]),
    .cmp_data  (ram_rdata[DATA_LO +: DATA_BITS]),
    .cmp_count (ram_rdata[COUNT_LO +: COUNT_W]),
    .cmp_stamp (ram_rdata[STAMP_LO +: STAMP_W]),
    .cmp_dl    (ram_rdata[TIME_W-1:0]),
    .key       (key_r),
    .flags     (flags),
    .match_idx (match_idx),
    .m_data    (m_data),
    .m_count   (m_count),
    .m_stamp   (m_stamp),
    .m_dl      (m_dl),
    .vic_idx   (vic_idx),
    .vic_key   (vic_key),
    .free_idx  (free_idx),
    .live      (live)
  );

  assign busy  = (state_r != ST_IDLE);
  assign clear = (state_r == ST_IDLE) && start;

  // Capacity zero acts as one; values above the entry count are clamped.
  always_comb begin
    cap_eff = (cap_r == '0) ? CMP_W'(1) : CMP_W'(cap_r);
    if (cap_eff > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  assign do_evict = flags.victim_ok && (CMP_W'(live) >= cap_eff);
  // A new entry goes to the lowest slot that is free after the eviction.
  assign slot = (flags.free_ok && (!do_evict || (free_idx < vic_idx))) ? free_idx : vic_idx;
  assign expired  = hasdl_r[match_idx] && (now_r > m_dl);
  assign dl_sum   = {1'b0, now_r} + (TIME_W + 1)'(secs_r);
  assign m_dl_upd = dl_sum[TIME_W] ? '1 : dl_sum[TIME_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    valid_nxt  = valid_r;
    hasdl_nxt  = hasdl_r;
    now_nxt    = now_r;
    seq_nxt    = seq_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    ram_we     = 1'b0;
    ram_waddr  = match_idx;
    ram_wdata  = {key_r, m_data, m_count, m_stamp, m_dl};
    hit_nxt    = 1'b0;
    rd_nxt     = '0;
    ev_nxt     = 1'b0;
    evk_nxt    = '0;
    unique case (state_r)
      ST_IDLE: begin
        addr_nxt = '0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + IDX_W'(1);
        if (addr_r == IDX_W'(ENTRIES - 1)) begin
          addr_nxt  = '0;
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        unique case (kind_r)
          KIND_GET: begin
            if (flags.found && !expired) begin
              hit_nxt = 1'b1;
              rd_nxt  = m_data;
              if (hits_r != '1) begin
                hits_nxt = hits_r + TOTAL_W'(1);
              end
              if (m_count < COUNT_MAX) begin
                ram_we    = 1'b1;
                ram_wdata = {key_r, m_data, m_count + COUNT_W'(1), seq_r, m_dl};
                seq_nxt   = seq_r + STAMP_W'(1);
              end
            end else begin
              if (flags.found) begin
                valid_nxt[match_idx] = 1'b0;
                hasdl_nxt[match_idx] = 1'b0;
              end
              if (misses_r != '1) begin
                misses_nxt = misses_r + TOTAL_W'(1);
              end
            end
          end
          KIND_PUT: begin
            ram_we    = 1'b1;
            ram_wdata = {key_r, value_r, COUNT_W'(1), seq_r, m_dl};
            seq_nxt   = seq_r + STAMP_W'(1);
            if (flags.found) begin
              hasdl_nxt[match_idx] = 1'b0;
            end else begin
              if (do_evict) begin
                ev_nxt   = 1'b1;
                evk_nxt  = vic_key;
                valid_nxt[vic_idx] = 1'b0;
              end
              ram_waddr       = slot;
              valid_nxt[slot] = 1'b1;
              hasdl_nxt[slot] = 1'b0;
            end
          end
          KIND_ERASE: begin
            if (flags.found) begin
              valid_nxt[match_idx] = 1'b0;
              hasdl_nxt[match_idx] = 1'b0;
            end
          end
          KIND_SETEXP: begin
            if (flags.found) begin
              ram_we    = 1'b1;
              ram_wdata = {key_r, m_data, m_count, m_stamp, m_dl_upd};
              hasdl_nxt[match_idx] = 1'b1;
            end
          end
          KIND_TICK: begin
            if (now_r != '1) begin
              now_nxt = now_r + TIME_W'(1);
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      addr_r    <= '0;
      cmp_en_r  <= 1'b0;
      valid_r   <= '0;
      hasdl_r   <= '0;
      now_r     <= '0;
      seq_r     <= '0;
      hits_r    <= '0;
      misses_r  <= '0;
      cap_r     <= CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      addr_r    <= addr_nxt;
      cmp_en_r  <= (state_r == ST_SCAN);
      valid_r   <= valid_nxt;
      hasdl_r   <= hasdl_nxt;
      now_r     <= now_nxt;
      seq_r     <= seq_nxt;
      hits_r    <= hits_nxt;
      misses_r  <= misses_nxt;
      out_valid <= (state_r == ST_EXEC);
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= addr_r;
    if (clear) begin
      kind_r  <= in_kind;
      key_r   <= in_key;
      value_r <= in_value;
      secs_r  <= in_seconds;
    end
    if (state_r == ST_EXEC) begin
      out_hit         <= hit_nxt;
      out_read_value  <= rd_nxt;
      out_hit_count   <= hits_nxt;
      out_miss_count  <= misses_nxt;
      out_evicted     <= ev_nxt;
      out_evicted_key <= evk_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/lfucx_checker.sv -----
// ----------------------------------------------------------------------------
// lfucx_checker
// Port-level checks of the LFU cache, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_cache_with_expiry_top_macros.svh"
module lfucx_checker #(
  parameter int KEY_BITS  = 32,
  parameter int DATA_BITS = 32
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire logic                 out_valid,
  input wire logic                 out_hit,
  input wire logic [DATA_BITS-1:0] out_read_value,
  input wire logic                 out_evicted,
  input wire logic [KEY_BITS-1:0]  out_evicted_key
);
  // An accepted item keeps the block busy until its result is out.
  `LFUCX_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy && !out_valid)
  `LFUCX_ASSERT_IMPLY(a_result_idle, clk, rst_n, out_valid, !busy)
  `LFUCX_ASSERT_IMPLY(a_miss_zero, clk, rst_n, out_valid && !out_hit, out_read_value == '0)
  `LFUCX_ASSERT_IMPLY(a_hit_no_evict, clk, rst_n, out_valid && out_hit, !out_evicted)
  `LFUCX_ASSERT_IMPLY(a_evk_zero, clk, rst_n, out_valid && !out_evicted,
                      out_evicted_key == '0)
endmodule

bind lfu_cache_with_expiry_top lfucx_checker #(
  .KEY_BITS(KEY_BITS), .DATA_BITS(DATA_BITS)
) u_lfucx_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_hit         (out_hit),
  .out_read_value  (out_read_value),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key)
);
`default_nettype wire
